FILE: design/fp64_ieee_remainder_unit_assert.svh
// Assertion macros for the remainder unit
`ifndef FP64_IEEE_REMAINDER_UNIT_ASSERT_SVH
`define FP64_IEEE_REMAINDER_UNIT_ASSERT_SVH
`define FPR_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FPR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/fpr_pkg.sv
`default_nettype none
package fpr_pkg;
    localparam int MANT_W = 53;
    localparam int EXP_W  = 12;
    localparam logic [63:0] DEFAULT_NAN = 64'h7FF8000000000000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008000000000000;
    localparam logic [63:0] EXP_MASK    = 64'h7FF0000000000000;

    typedef struct packed {
        logic        start;
        logic [52:0] mx;
        logic [52:0] my;
        logic [11:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [52:0] r;
        logic        q;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: design/fp64_ieee_remainder_unit.sv
`default_nettype none
// Channel   | Ports                                    | Transfer
// command   | start, dividend_bits, divisor_bits       | start && !busy
// result    | done, remainder_bits                     | done (one cycle)
//
// Nonspecial commands are normalized, then may pass through the shift-subtract divider
// and the bit-serial packer; special operands go straight to the output.
// Subnormal operands are normalized by shifting out one leading zero at a time.
// Reset clears control only. The result cannot be stalled: done is a one-cycle
// strobe and the next command waits until it is shown.
module fp64_ieee_remainder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend_bits,
    input  wire logic [63:0] divisor_bits,
    output logic             busy,
    output logic             done,
    output logic [63:0]      remainder_bits
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_PACK = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  st_reg, st_next;
    logic [63:0] x_reg, x_next;
    logic [52:0] mx_reg, mx_next, my_reg, my_next;
    logic [12:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [52:0] rr_reg, rr_next;
    logic [12:0] eu_reg, eu_next;
    logic        sg_reg, sg_next;
    logic [63:0] out_reg, out_next;
    logic        done_reg, done_next;
    logic        fire;
    logic        x_nan, y_nan;
    logic [63:0] ax, ay;
    logic [12:0] diff;
    logic [53:0] r2;
    fpr_pkg::div_cmd_t dcmd;
    fpr_pkg::div_rsp_t drsp;
    logic        pk_start, pk_done;
    logic [63:0] pk_res;

    assign fire  = start && !busy;
    assign ax    = {1'b0, dividend_bits[62:0]};
    assign ay    = {1'b0, divisor_bits[62:0]};
    assign x_nan = dividend_bits[62:52] == 11'h7FF && dividend_bits[51:0] != 52'd0;
    assign y_nan = divisor_bits[62:52] == 11'h7FF && divisor_bits[51:0] != 52'd0;
    assign diff  = ex_reg - ey_reg;
    assign r2    = {drsp.r, 1'b0};

    always_comb
    begin
        st_next   = st_reg;
        x_next    = x_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        ex_next   = ex_reg;
        ey_next   = ey_reg;
        rr_next   = rr_reg;
        eu_next   = eu_reg;
        sg_next   = sg_reg;
        out_next  = out_reg;
        done_next = 1'b0;
        dcmd      = '0;
        pk_start  = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    x_next  = dividend_bits;
                    sg_next = dividend_bits[63];
                    mx_next = {dividend_bits[62:52] != 11'd0, dividend_bits[51:0]};
                    my_next = {divisor_bits[62:52] != 11'd0, divisor_bits[51:0]};
                    ex_next = (dividend_bits[62:52] == 11'd0) ? 13'd1
                                                              : {2'd0, dividend_bits[62:52]};
                    ey_next = (divisor_bits[62:52] == 11'd0) ? 13'd1
                                                             : {2'd0, divisor_bits[62:52]};
                    // settle special operands at once
                    if (x_nan)
                    begin
                        out_next = dividend_bits | fpr_pkg::QUIET_BIT;
                        st_next  = S_OUT;
                    end
                    else if (y_nan)
                    begin
                        out_next = divisor_bits | fpr_pkg::QUIET_BIT;
                        st_next  = S_OUT;
                    end
                    else if (ax == fpr_pkg::EXP_MASK || ay == 64'd0)
                    begin
                        out_next = fpr_pkg::DEFAULT_NAN;
                        st_next  = S_OUT;
                    end
                    else if (ay == fpr_pkg::EXP_MASK || ax == 64'd0)
                    begin
                        out_next = dividend_bits;
                        st_next  = S_OUT;
                    end
                    else
                        st_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // advance subnormal significands one bit a cycle
                if (!mx_reg[52])
                begin
                    mx_next = mx_reg << 1;
                    ex_next = ex_reg - 13'd1;
                end
                else if (!my_reg[52])
                begin
                    my_next = my_reg << 1;
                    ey_next = ey_reg - 13'd1;
                end
                else if ($signed(ex_reg) < $signed(ey_reg - 13'd1))
                begin
                    out_next = x_reg;
                    st_next  = S_OUT;
                end
                else if (ex_reg == ey_reg - 13'd1)
                begin
                    eu_next = ex_reg;
                    if (mx_reg > my_reg)
                    begin
                        rr_next = 53'({my_reg, 1'b0} - {1'b0, mx_reg});
                        sg_next = ~sg_reg;
                    end
                    else
                        rr_next = mx_reg;
                    st_next = S_FOLD;
                end
                else
                begin
                    dcmd.start = 1'b1;
                    dcmd.mx    = mx_reg;
                    dcmd.my    = my_reg;
                    dcmd.steps = diff[11:0];
                    eu_next    = ey_reg;
                    st_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    rr_next = drsp.r;
                    if (r2 > {1'b0, my_reg} || (r2 == {1'b0, my_reg} && drsp.q))
                    begin
                        rr_next = my_reg - drsp.r;
                        sg_next = ~sg_reg;
                    end
                    st_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                if (rr_reg == 53'd0)
                begin
                    out_next = {x_reg[63], 63'd0};
                    st_next  = S_OUT;
                end
                else
                begin
                    pk_start = 1'b1;
                    st_next  = S_PACK;
                end
            end
            S_PACK:
            begin
                if (pk_done)
                begin
                    out_next = pk_res;
                    st_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        ex_reg  <= ex_next;
        ey_reg  <= ey_next;
        rr_reg  <= rr_next;
        eu_reg  <= eu_next;
        sg_reg  <= sg_next;
        out_reg <= out_next;
    end

    fpr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dcmd),
        .rsp   (drsp)
    );

    fpr_normalizer u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pk_start),
        .sign   (sg_reg),
        .r      (rr_reg),
        .eu     (eu_reg),
        .done   (pk_done),
        .result (pk_res)
    );

    assign busy           = st_reg != S_IDLE || done_reg;
    assign done           = done_reg;
    assign remainder_bits = out_reg;

`include "fp64_ieee_remainder_unit_assert.svh"
    `FPR_ASSERT_NEXT(a_fire_busy, clk, rst_n, fire, busy)
    `FPR_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `FPR_ASSERT_IMPL(a_div_in_state, clk, rst_n, drsp.done, st_reg == S_DIV)
endmodule
`default_nettype wire

FILE: design/fpr_divider.sv
`default_nettype none
// Shift-subtract loop: one remainder step per cycle, quotient parity kept.
module fpr_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fpr_pkg::div_cmd_t cmd,
    output fpr_pkg::div_rsp_t      rsp
);
    logic        busy_reg, busy_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [53:0] r_reg, r_next;
    logic [52:0] my_reg, my_next;
    logic        q_reg, q_next, done_reg, done_next;
    logic        ge;
    logic [53:0] sub;

    assign ge  = r_reg >= {1'b0, my_reg};
    assign sub = ge ? (r_reg - {1'b0, my_reg}) : r_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        my_next   = my_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            r_next    = {1'b0, cmd.mx};
            my_next   = cmd.my;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 12'd0)
            begin
                // subtract then double
                r_next   = {sub[52:0], 1'b0};
                cnt_next = cnt_reg - 12'd1;
            end
            else
            begin
                r_next    = sub;
                q_next    = ge;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        my_reg  <= my_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.r    = r_reg[52:0];
    assign rsp.q    = q_reg;
endmodule
`default_nettype wire

FILE: design/fpr_normalizer.sv
`default_nettype none
// Bit-serial packer: shift right for subnormals, left to normalize, one bit a cycle.
module fpr_normalizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        sign,
    input  wire logic [52:0] r,
    input  wire logic [12:0] eu,
    output logic             done,
    output logic [63:0]      result
);
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [52:0] r_reg, r_next;
    logic [12:0] e_reg, e_next;
    logic        s_reg, s_next;

    always_comb
    begin
        busy_next = busy_reg;
        r_next    = r_reg;
        e_next    = e_reg;
        s_next    = s_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            r_next    = r;
            e_next    = eu;
            s_next    = sign;
        end
        else if (busy_reg)
        begin
            if ($signed(e_reg) < 13'sd1)
            begin
                // drop one bit toward the subnormal range
                r_next = r_reg >> 1;
                e_next = e_reg + 13'd1;
            end
            else if (!r_reg[52] && e_reg != 13'd1)
            begin
                r_next = r_reg << 1;
                e_next = e_reg - 13'd1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        e_reg <= e_next;
        s_reg <= s_next;
    end

    assign done   = done_reg;
    assign result = r_reg[52] ? {s_reg, e_reg[10:0], r_reg[51:0]}
                              : {s_reg, 11'd0, r_reg[51:0]};
endmodule
`default_nettype wire
